[sv/aesp_pkg.sv]
// shared constants, codes and types of the ansi escape sequence parser
`timescale 1ns / 1ps

package aesp_pkg;

	// parameter store depth and the usable number of slots
	localparam int MAX_PARAMS  = 16;
	localparam int STORE_DEPTH = 16;
	localparam int P_LIMIT     = (MAX_PARAMS < 1) ? 1 :
		((MAX_PARAMS > STORE_DEPTH) ? STORE_DEPTH : MAX_PARAMS);
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = $clog2(STORE_DEPTH + 1);
	localparam int VAL_W       = 16;

	// bytes with a fixed meaning
	localparam logic [7:0] C_ESC      = 8'h1b;
	localparam logic [7:0] C_CSI      = 8'h5b;
	localparam logic [7:0] C_OSC      = 8'h5d;
	localparam logic [7:0] C_BEL      = 8'h07;
	localparam logic [7:0] C_SEMI     = 8'h3b;
	localparam logic [7:0] C_EXEC_MAX = 8'h17;
	localparam logic [7:0] C_PR_MIN   = 8'h20;
	localparam logic [7:0] C_PR_MAX   = 8'h7f;
	localparam logic [7:0] C_U8_MIN   = 8'hc2;
	localparam logic [7:0] C_U8_2MAX  = 8'hdf;
	localparam logic [7:0] C_U8_3MAX  = 8'hef;
	localparam logic [7:0] C_U8_MAX   = 8'hf4;
	localparam logic [7:0] C_DIG_MIN  = 8'h30;
	localparam logic [7:0] C_DIG_MAX  = 8'h39;
	localparam logic [7:0] C_MRK_MIN  = 8'h3c;
	localparam logic [7:0] C_MRK_MAX  = 8'h3f;
	localparam logic [7:0] C_FIN_MIN  = 8'h40;
	localparam logic [7:0] C_FIN_MAX  = 8'h7e;

	// event kinds
	localparam logic [2:0] EV_EXEC    = 3'd0;
	localparam logic [2:0] EV_PRINT   = 3'd1;
	localparam logic [2:0] EV_CSI     = 3'd2;
	localparam logic [2:0] EV_OSCBYTE = 3'd3;
	localparam logic [2:0] EV_OSCEND  = 3'd4;
	localparam logic [2:0] EV_ERROR   = 3'd5;

	typedef struct packed {
		logic [2:0]        kind;
		logic [31:0]       data;
		logic [2:0]        len;
		logic [7:0]        fin_byte;
		logic [7:0]        marker;
		logic [SLOT_W-1:0] count;
		logic [IDX_W-1:0]  index;
		logic [VAL_W-1:0]  value;
		logic              ovf;
		logic              last;
	} aesp_event_t;

endpackage

[sv/ansi_escape_sequence_parser_top.sv]
// top level of the ansi escape sequence parser with its output register
`timescale 1ns / 1ps

// Terminal byte parser (ground, escape, CSI, OSC and UTF-8 states). Each byte
// accepted on the slave side yields zero or more words on the master side; the
// final word of a byte's results carries tlast. Ordinary bytes pass at one per
// cycle while the master side keeps up. A CSI final byte is held until its
// dispatch run is done; the run reads the parameter memory through its single
// read port one slot per cycle while the master side keeps up. CSI parameter
// digits are accumulated by read-modify-write of that memory, with the previous
// write forwarded. Stored slots carry valid bits cleared on CSI entry, so there
// is no clearing pass after reset. A word waiting in the output register holds
// back a byte that has a word of its own to send, and that byte then holds the
// slave side; bytes with no word still pass.
module ansi_escape_sequence_parser_top
	import aesp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // byte_in[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// data_bytes[31:0], data_len[34:32], final_byte[42:35], private_marker[50:43],
	// param_count[55:51], param_index[59:56], param_value[75:60],
	// param_overflow[76], zero[79:77]
	output logic [79:0] m_tdata,
	output logic [2:0]  m_tuser,  // event_kind[2:0]
	output logic        m_tlast
);

	logic        ev_valid;
	logic        ev_ready;
	aesp_event_t ev;
	logic        out_v_q;
	aesp_event_t out_q;

	aesp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.ev_valid (ev_valid),
		.ev       (ev),
		.ev_ready (ev_ready)
	);

	assign ev_ready = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			if (ev_valid && ev_ready) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && ev_ready) begin
			out_q <= ev;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {3'b000, out_q.ovf, out_q.value, out_q.index, out_q.count,
		out_q.marker, out_q.fin_byte, out_q.len, out_q.data};

endmodule

[sv/aesp_param_ram.sv]
// generic single-write single-read memory with registered read data
`timescale 1ns / 1ps

module aesp_param_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/aesp_parser.sv]
// parser state machine around the parameter memory, with the dispatch sequencer
`timescale 1ns / 1ps

module aesp_parser
	import aesp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        ev_valid,
	output aesp_event_t ev,
	input  logic        ev_ready
);

	localparam logic [2:0] ST_GROUND   = 3'd0;
	localparam logic [2:0] ST_ESCAPE   = 3'd1;
	localparam logic [2:0] ST_CSIENTRY = 3'd2;
	localparam logic [2:0] ST_CSIPARAM = 3'd3;
	localparam logic [2:0] ST_OSC      = 3'd4;
	localparam logic [2:0] ST_UTF8     = 3'd5;

	// byte under work
	logic              vld_s1;
	logic [7:0]        byte_s1;
	logic              fwd_s1;
	logic [VAL_W-1:0]  fwd_val_s1;

	// parser state
	logic [2:0]             state_q;
	logic [SLOT_W-1:0]      slots_q;
	logic [7:0]             marker_q;
	logic                   ovf_q;
	logic                   spill_q;
	logic [31:0]            u8_bytes_q;
	logic [2:0]             u8_cnt_q;
	logic [2:0]             u8_rem_q;
	logic [STORE_DEPTH-1:0] pvalid_q;

	// dispatch sequencer
	logic             disp_q;
	logic [IDX_W-1:0] k_q;

	// next-state values
	logic [2:0]        st;
	logic [2:0]        st_nxt;
	logic [SLOT_W-1:0] slots_nxt;
	logic [7:0]        marker_nxt;
	logic              ovf_nxt;
	logic              spill_nxt;
	logic [31:0]       u8_bytes_nxt;
	logic [2:0]        u8_cnt_nxt;
	logic [2:0]        u8_rem_nxt;
	logic              clr;
	logic              is_disp;
	logic              ev_need;
	aesp_event_t       ev_c;

	// memory access
	logic              wr_en_c;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [VAL_W-1:0]  wr_data;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	logic              s1_done;
	logic              accept;
	logic              disp_last;
	logic              disp_start;
	logic [SLOT_W-1:0] n_items;
	logic [SLOT_W-1:0] s_eff;
	logic [SLOT_W-1:0] s_eff_m1;
	logic [VAL_W-1:0]  cur_val;
	logic [19:0]       prod;
	logic [SLOT_W-1:0] slots_sel;
	logic [SLOT_W-1:0] slots_sel_m1;
	logic [IDX_W-1:0]  acc_idx;
	logic [VAL_W-1:0]  disp_val;

	aesp_param_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// slot in use for digits; an empty list opens slot one
	assign s_eff    = (slots_q == '0) ? SLOT_W'(1) : slots_q;
	assign s_eff_m1 = s_eff - SLOT_W'(1);

	// value of the open slot: last write forwarded, never-written slots read zero
	always_comb begin
		if (fwd_s1) begin
			cur_val = fwd_val_s1;
		end else if (pvalid_q[s_eff_m1[IDX_W-1:0]]) begin
			cur_val = ram_rdata;
		end else begin
			cur_val = '0;
		end
	end

	assign prod = {1'b0, cur_val, 3'b000} + {3'b000, cur_val, 1'b0}
		+ {16'd0, byte_s1[3:0] - C_DIG_MIN[3:0]};

	always_comb begin
		st           = (state_q > ST_UTF8) ? ST_GROUND : state_q;
		st_nxt       = st;
		slots_nxt    = slots_q;
		marker_nxt   = marker_q;
		ovf_nxt      = ovf_q;
		spill_nxt    = spill_q;
		u8_bytes_nxt = u8_bytes_q;
		u8_cnt_nxt   = u8_cnt_q;
		u8_rem_nxt   = u8_rem_q;
		clr          = 1'b0;
		is_disp      = 1'b0;
		ev_need      = 1'b0;
		ev_c         = '0;
		ev_c.last    = 1'b1;
		wr_en_c      = 1'b0;
		wr_addr      = s_eff_m1[IDX_W-1:0];
		wr_data      = '0;

		if (byte_s1 == C_ESC) begin
			if (st == ST_OSC) begin
				ev_need   = 1'b1;
				ev_c.kind = EV_OSCEND;
			end
			st_nxt = ST_ESCAPE;
		end else begin
			case (st)
				ST_UTF8: begin
					if (u8_cnt_q < 3'd4) begin
						u8_bytes_nxt = u8_bytes_q | (32'(byte_s1) << {u8_cnt_q[1:0], 3'b000});
						u8_cnt_nxt   = u8_cnt_q + 3'd1;
					end
					if (u8_rem_q != 3'd0) begin
						u8_rem_nxt = u8_rem_q - 3'd1;
					end
					if (u8_rem_nxt == 3'd0) begin
						ev_need   = 1'b1;
						ev_c.kind = EV_PRINT;
						ev_c.data = u8_bytes_nxt;
						ev_c.len  = u8_cnt_nxt;
						st_nxt    = ST_GROUND;
					end
				end
				ST_ESCAPE: begin
					if (byte_s1 == C_CSI) begin
						st_nxt       = ST_CSIENTRY;
						clr          = 1'b1;
						slots_nxt    = '0;
						marker_nxt   = '0;
						ovf_nxt      = 1'b0;
						spill_nxt    = 1'b0;
						u8_bytes_nxt = '0;
						u8_cnt_nxt   = '0;
						u8_rem_nxt   = '0;
					end else if (byte_s1 == C_OSC) begin
						st_nxt = ST_OSC;
					end else begin
						ev_need   = 1'b1;
						ev_c.kind = EV_ERROR;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end
				end
				ST_CSIENTRY, ST_CSIPARAM: begin
					if (byte_s1 == C_SEMI) begin
						st_nxt = ST_CSIPARAM;
						if (s_eff < SLOT_W'(P_LIMIT)) begin
							slots_nxt = s_eff + SLOT_W'(1);
						end else begin
							slots_nxt = s_eff;
							ovf_nxt   = 1'b1;
							spill_nxt = 1'b1;
						end
					end else if (byte_s1 >= C_DIG_MIN && byte_s1 <= C_DIG_MAX) begin
						st_nxt    = ST_CSIPARAM;
						slots_nxt = s_eff;
						if (!spill_q) begin
							wr_en_c = 1'b1;
							if (prod > 20'hffff) begin
								wr_data = '1;
								ovf_nxt = 1'b1;
							end else begin
								wr_data = prod[VAL_W-1:0];
							end
						end
					end else if (st == ST_CSIENTRY && byte_s1 >= C_MRK_MIN
						&& byte_s1 <= C_MRK_MAX) begin
						marker_nxt = byte_s1;
						st_nxt     = ST_CSIPARAM;
					end else if (byte_s1 >= C_FIN_MIN && byte_s1 <= C_FIN_MAX) begin
						is_disp = 1'b1;
						st_nxt  = ST_GROUND;
					end else begin
						ev_need   = 1'b1;
						ev_c.kind = EV_ERROR;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end
				end
				ST_OSC: begin
					if (byte_s1 == C_BEL) begin
						ev_need   = 1'b1;
						ev_c.kind = EV_OSCEND;
						st_nxt    = ST_GROUND;
					end else if (byte_s1 >= C_PR_MIN && byte_s1 <= C_PR_MAX) begin
						ev_need   = 1'b1;
						ev_c.kind = EV_OSCBYTE;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end else begin
						ev_need   = 1'b1;
						ev_c.kind = EV_ERROR;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end
				end
				default: begin
					st_nxt = ST_GROUND;
					if (byte_s1 <= C_EXEC_MAX) begin
						ev_need   = 1'b1;
						ev_c.kind = EV_EXEC;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end else if (byte_s1 >= C_PR_MIN && byte_s1 <= C_PR_MAX) begin
						ev_need   = 1'b1;
						ev_c.kind = EV_PRINT;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end else if (byte_s1 >= C_U8_MIN && byte_s1 <= C_U8_MAX) begin
						u8_bytes_nxt = 32'(byte_s1);
						u8_cnt_nxt   = 3'd1;
						if (byte_s1 <= C_U8_2MAX) begin
							u8_rem_nxt = 3'd1;
						end else if (byte_s1 <= C_U8_3MAX) begin
							u8_rem_nxt = 3'd2;
						end else begin
							u8_rem_nxt = 3'd3;
						end
						st_nxt = ST_UTF8;
					end else begin
						ev_need   = 1'b1;
						ev_c.kind = EV_ERROR;
						ev_c.data = 32'(byte_s1);
						ev_c.len  = 3'd1;
					end
				end
			endcase
		end
	end

	// dispatch run: one word per parameter slot, read from memory in order
	assign n_items   = (slots_q == '0) ? SLOT_W'(1) : slots_q;
	assign disp_last = (SLOT_W'(k_q) + SLOT_W'(1)) == n_items;
	assign disp_val  = (slots_q != '0 && pvalid_q[k_q]) ? ram_rdata : '0;
	assign disp_start = vld_s1 && is_disp && !disp_q;

	always_comb begin
		if (is_disp) begin
			ev          = '0;
			ev.kind     = EV_CSI;
			ev.fin_byte = byte_s1;
			ev.marker   = marker_q;
			ev.count    = slots_q;
			ev.index    = k_q;
			ev.value    = disp_val;
			ev.ovf      = ovf_q;
			ev.last     = disp_last;
		end else begin
			ev = ev_c;
		end
	end

	assign ev_valid = vld_s1 && (is_disp ? disp_q : ev_need);

	always_comb begin
		if (!vld_s1) begin
			s1_done = 1'b0;
		end else if (is_disp) begin
			s1_done = disp_q && ev_ready && disp_last;
		end else begin
			s1_done = !ev_need || ev_ready;
		end
	end

	assign in_ready = !vld_s1 || s1_done;
	assign accept   = in_valid && in_ready;
	assign wr_en    = wr_en_c && s1_done;

	// read address for the incoming byte follows the slot count it will see
	assign slots_sel    = s1_done ? slots_nxt : slots_q;
	assign slots_sel_m1 = slots_sel - SLOT_W'(1);
	assign acc_idx      = (slots_sel == '0) ? '0 : slots_sel_m1[IDX_W-1:0];

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = acc_idx;
		if (accept) begin
			ram_re = 1'b1;
		end else if (disp_start) begin
			ram_re    = 1'b1;
			ram_raddr = '0;
		end else if (disp_q && ev_ready && !disp_last) begin
			ram_re    = 1'b1;
			ram_raddr = k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				fwd_s1 <= wr_en && (wr_addr == acc_idx);
			end else if (s1_done) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1    <= in_byte;
			fwd_val_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_GROUND;
			slots_q    <= '0;
			marker_q   <= '0;
			ovf_q      <= 1'b0;
			spill_q    <= 1'b0;
			u8_bytes_q <= '0;
			u8_cnt_q   <= '0;
			u8_rem_q   <= '0;
			pvalid_q   <= '0;
			disp_q     <= 1'b0;
			k_q        <= '0;
		end else begin
			if (s1_done) begin
				state_q    <= st_nxt;
				slots_q    <= slots_nxt;
				marker_q   <= marker_nxt;
				ovf_q      <= ovf_nxt;
				spill_q    <= spill_nxt;
				u8_bytes_q <= u8_bytes_nxt;
				u8_cnt_q   <= u8_cnt_nxt;
				u8_rem_q   <= u8_rem_nxt;
				if (clr) begin
					pvalid_q <= '0;
				end else if (wr_en) begin
					pvalid_q[wr_addr] <= 1'b1;
				end
			end
			if (disp_start) begin
				disp_q <= 1'b1;
				k_q    <= '0;
			end else if (disp_q && ev_ready) begin
				if (disp_last) begin
					disp_q <= 1'b0;
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

[tb/ansi_escape_sequence_parser_top_tb.sv]
// testbench of the ansi escape sequence parser top level with its own event predictor
`timescale 1ns / 1ps

module ansi_escape_sequence_parser_top_tb;
	import aesp_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [2:0] {
		PS_GROUND,
		PS_ESCAPE,
		PS_CSI_ENTRY,
		PS_CSI_PARAM,
		PS_OSC,
		PS_UTF8
	} parse_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // byte_in[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// data_bytes[31:0], data_len[34:32], final_byte[42:35], private_marker[50:43],
	// param_count[55:51], param_index[59:56], param_value[75:60],
	// param_overflow[76], zero[79:77]
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;           // event_kind[2:0]
	logic        m_tlast;

	// parser state mirrored by the predictor
	parse_state_t      ps = PS_GROUND;
	logic [VAL_W-1:0]  param_mem [STORE_DEPTH];
	int                slots = 0;
	logic [7:0]        csi_marker = 8'h00;
	logic              csi_ovf = 1'b0;
	logic              spill = 1'b0;
	logic [31:0]       u8_bytes = 32'h0;
	logic [2:0]        u8_count = 3'd0;
	logic [2:0]        u8_left = 3'd0;

	aesp_event_t pending_events [$];
	int          errors = 0;
	int          stuck_cycles = 0;
	int          bytes_sent = 0;
	bit          tx_idle_en = 1'b0;
	bit          rx_idle_en = 1'b0;
	bit          hold_request = 1'b0;

	ansi_escape_sequence_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (param_mem[i]) param_mem[i] = '0;
	end

	function automatic aesp_event_t simple_event(input logic [2:0] kind, input logic [31:0] data,
		input logic [2:0] len);
		aesp_event_t ev;
		ev = '0;
		ev.kind = kind;
		ev.data = data;
		ev.len = len;
		return ev;
	endfunction

	// expected words for one accepted byte
	task automatic predict_byte(input logic [7:0] c);
		aesp_event_t evs [$];
		aesp_event_t ev;
		int unsigned acc;
		int n;
		if (c == C_ESC) begin
			if (ps == PS_OSC) evs.push_back(simple_event(EV_OSCEND, 32'h0, 3'd0));
			ps = PS_ESCAPE;
		end else begin
			case (ps)
			PS_UTF8: begin
				// continuation bytes are taken without validation
				if (u8_count < 4) begin
					u8_bytes = u8_bytes | (32'(c) << (8 * u8_count));
					u8_count = u8_count + 3'd1;
				end
				if (u8_left > 0) u8_left = u8_left - 3'd1;
				if (u8_left == 0) begin
					evs.push_back(simple_event(EV_PRINT, u8_bytes, u8_count));
					ps = PS_GROUND;
				end
			end
			PS_GROUND: begin
				if (c <= C_EXEC_MAX) begin
					evs.push_back(simple_event(EV_EXEC, 32'(c), 3'd1));
				end else if (c >= C_PR_MIN && c <= C_PR_MAX) begin
					evs.push_back(simple_event(EV_PRINT, 32'(c), 3'd1));
				end else if (c >= C_U8_MIN && c <= C_U8_MAX) begin
					u8_bytes = 32'(c);
					u8_count = 3'd1;
					u8_left = (c <= C_U8_2MAX) ? 3'd1 : ((c <= C_U8_3MAX) ? 3'd2 : 3'd3);
					ps = PS_UTF8;
				end else begin
					evs.push_back(simple_event(EV_ERROR, 32'(c), 3'd1));
				end
			end
			PS_ESCAPE: begin
				if (c == C_CSI) begin
					ps = PS_CSI_ENTRY;
					foreach (param_mem[i]) param_mem[i] = '0;
					slots = 0;
					csi_marker = 8'h00;
					csi_ovf = 1'b0;
					spill = 1'b0;
					u8_bytes = 32'h0;
					u8_count = 3'd0;
					u8_left = 3'd0;
				end else if (c == C_OSC) begin
					ps = PS_OSC;
				end else begin
					evs.push_back(simple_event(EV_ERROR, 32'(c), 3'd1));
				end
			end
			PS_CSI_ENTRY, PS_CSI_PARAM: begin
				if ((c >= C_DIG_MIN && c <= C_DIG_MAX) || c == C_SEMI) begin
					if (slots == 0) slots = 1;
					if (c == C_SEMI) begin
						if (slots < P_LIMIT) begin
							slots++;
						end else begin
							// no slot left: drop digits until the dispatch
							csi_ovf = 1'b1;
							spill = 1'b1;
						end
					end else if (!spill) begin
						acc = param_mem[IDX_W'(slots - 1)] * 10 + (c - C_DIG_MIN);
						if (acc > 65535) begin
							acc = 65535;
							csi_ovf = 1'b1;
						end
						param_mem[IDX_W'(slots - 1)] = acc[15:0];
					end
					ps = PS_CSI_PARAM;
				end else if (ps == PS_CSI_ENTRY && c >= C_MRK_MIN && c <= C_MRK_MAX) begin
					csi_marker = c;
					ps = PS_CSI_PARAM;
				end else if (c >= C_FIN_MIN && c <= C_FIN_MAX) begin
					n = (slots == 0) ? 1 : slots;
					for (int k = 0; k < n; k++) begin
						ev = simple_event(EV_CSI, 32'h0, 3'd0);
						ev.fin_byte = c;
						ev.marker = csi_marker;
						ev.count = SLOT_W'(slots);
						ev.index = IDX_W'(k);
						ev.value = (slots == 0) ? '0 : param_mem[IDX_W'(k)];
						ev.ovf = csi_ovf;
						evs.push_back(ev);
					end
					ps = PS_GROUND;
				end else begin
					evs.push_back(simple_event(EV_ERROR, 32'(c), 3'd1));
				end
			end
			default: begin
				if (c == C_BEL) begin
					evs.push_back(simple_event(EV_OSCEND, 32'h0, 3'd0));
					ps = PS_GROUND;
				end else if (c >= C_PR_MIN && c <= C_PR_MAX) begin
					evs.push_back(simple_event(EV_OSCBYTE, 32'(c), 3'd1));
				end else begin
					evs.push_back(simple_event(EV_ERROR, 32'(c), 3'd1));
				end
			end
			endcase
		end
		if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i]) pending_events.push_back(evs[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_word();
		aesp_event_t want;
		if (pending_events.size() == 0) begin
			$display("%0t: unexpected word expected none actual kind %0d data 0x%0h",
				$time, m_tuser, m_tdata);
			errors++;
		end else begin
			want = pending_events.pop_front();
			check_field("event_kind", 32'(want.kind), 32'(m_tuser));
			check_field("data_bytes", want.data, m_tdata[31:0]);
			check_field("data_len", 32'(want.len), 32'(m_tdata[34:32]));
			check_field("final_byte", 32'(want.fin_byte), 32'(m_tdata[42:35]));
			check_field("private_marker", 32'(want.marker), 32'(m_tdata[50:43]));
			check_field("param_count", 32'(want.count), 32'(m_tdata[55:51]));
			check_field("param_index", 32'(want.index), 32'(m_tdata[59:56]));
			check_field("param_value", 32'(want.value), 32'(m_tdata[75:60]));
			check_field("param_overflow", 32'(want.ovf), 32'(m_tdata[76]));
			check_field("pad", 32'h0, 32'(m_tdata[79:77]));
			check_field("tlast", 32'(want.last), 32'(m_tlast));
		end
	endtask

	// both handshakes are sampled here, before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("ansi_escape_sequence_parser_top test failed");
				$finish;
			end else begin
				if (s_tvalid && s_tready) predict_byte(s_tdata);
				if (m_tvalid && m_tready) check_word();
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one byte; returns right after the edge that took it
	task automatic send_byte(input logic [7:0] b);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_csi(input int nparams);
		int ndig;
		send_byte(C_ESC);
		send_byte(C_CSI);
		if ($urandom_range(0, 3) == 0) send_byte(8'(C_MRK_MIN + $urandom_range(0, 3)));
		for (int i = 0; i < nparams; i++) begin
			if (i > 0) send_byte(C_SEMI);
			ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
			for (int j = 0; j < ndig; j++) send_byte(8'(C_DIG_MIN + $urandom_range(0, 9)));
		end
		// stray byte inside the sequence now and then
		if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(C_FIN_MIN, C_FIN_MAX)));
	endtask

	task automatic send_random_sequence();
		int pick;
		int cnt;
		logic [7:0] lead;
		pick = $urandom_range(0, 9);
		if (pick <= 2) begin
			cnt = $urandom_range(1, 6);
			for (int i = 0; i < cnt; i++) send_byte(8'($urandom_range(C_PR_MIN, C_PR_MAX)));
		end else if (pick == 3) begin
			send_byte(8'($urandom_range(0, C_EXEC_MAX)));
		end else if (pick <= 5) begin
			lead = 8'($urandom_range(C_U8_MIN, C_U8_MAX));
			cnt = (lead <= C_U8_2MAX) ? 1 : ((lead <= C_U8_3MAX) ? 2 : 3);
			send_byte(lead);
			for (int i = 0; i < cnt; i++) begin
				// an escape drops the partial character
				if ($urandom_range(0, 11) == 0) send_byte(C_ESC);
				else send_byte(8'($urandom_range(8'h80, 8'hbf)));
			end
		end else if (pick <= 7) begin
			send_csi(($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 4));
		end else if (pick == 8) begin
			send_byte(C_ESC);
			send_byte(C_OSC);
			cnt = $urandom_range(0, 8);
			for (int i = 0; i < cnt; i++) begin
				if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
				else send_byte(8'($urandom_range(C_PR_MIN, C_PR_MAX)));
			end
			send_byte(($urandom_range(0, 3) == 0) ? C_ESC : C_BEL);
		end else begin
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed_cases();
		logic [7:0] seq [$];
		seq = '{8'h00, C_EXEC_MAX, 8'h18, C_PR_MIN, C_PR_MAX, 8'hff,
			C_U8_MIN, 8'ha9,
			C_U8_MAX, 8'h8f, 8'hbf, 8'hbf,
			C_U8_3MAX, C_ESC,
			C_CSI, C_MRK_MAX, 8'h37, 8'h30, 8'h30, 8'h30, 8'h30, 8'h68,
			C_ESC, C_OSC, 8'h41, C_ESC,
			C_CSI, C_FIN_MIN,
			C_ESC, C_OSC, C_BEL,
			C_ESC, 8'h41};
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	task automatic test_random_sequences(input int target);
		int stop_at;
		stop_at = bytes_sent + target;
		while (bytes_sent < stop_at) send_random_sequence();
	endtask

	// receiver holds off while long dispatch runs keep arriving
	task automatic test_output_hold_off();
		hold_request = 1'b1;
		for (int r = 0; r < 2; r++) begin
			send_byte(C_ESC);
			send_byte(C_CSI);
			for (int i = 0; i < 12; i++) begin
				if (i > 0) send_byte(C_SEMI);
				send_byte(8'(C_DIG_MIN + $urandom_range(0, 9)));
			end
			send_byte(8'h6d);
		end
		for (int i = 0; i < 10; i++) send_byte(8'($urandom_range(C_PR_MIN, C_PR_MAX)));
	endtask

	task automatic test_back_to_back(input int target);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_sequences(target);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		test_directed_cases();
		test_random_sequences(85);
		test_output_hold_off();
		test_back_to_back(40);
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("ansi_escape_sequence_parser_top test passed");
		else
			$display("ansi_escape_sequence_parser_top test failed");
		$finish;
	end

endmodule
